[rtl/core/ifrx_pkg.sv]
// ----------------------------------------------------------------------------
// ifrx_pkg
// Shared types for the idle-framed receive byte ring.
// ----------------------------------------------------------------------------
package ifrx_pkg;

   // command code carried in req_tuser
   typedef enum logic [1:0] {
      CMD_STORE = 2'd0,
      CMD_IDLE  = 2'd1,
      CMD_READ  = 2'd2,
      CMD_FLUSH = 2'd3
   } cmd_type;

   // controller states
   typedef enum logic {
      S_IDLE = 1'b0,
      S_RESP = 1'b1
   } state_type;

   // one-hot step strobes from controller to datapath
   typedef struct packed {
      logic do_store;
      logic do_idle;
      logic do_read;
      logic do_flush;
   } dp_cmd_type;

   // field widths of the result word
   localparam int unsigned DATA_W    = 8;
   localparam int unsigned WAITING_W = 4;

endpackage

[rtl/core/ifrx_ctrl.sv]
// ----------------------------------------------------------------------------
// ifrx_ctrl
// Handshake controller: takes one word, issues one step, holds the result.
// ----------------------------------------------------------------------------
module ifrx_ctrl
   import ifrx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [1:0] req_cmd,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output dp_cmd_type dp_cmd
);

   state_type state_ff, state_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_tready = (state_ff == S_IDLE);
      rsp_tvalid = (state_ff == S_RESP);
      accept     = req_tvalid && req_tready;
      dp_cmd     = '0;
      if (accept) begin
         case (cmd_type'(req_cmd))
            CMD_STORE: dp_cmd.do_store = 1'b1;
            CMD_IDLE:  dp_cmd.do_idle  = 1'b1;
            CMD_READ:  dp_cmd.do_read  = 1'b1;
            CMD_FLUSH: dp_cmd.do_flush = 1'b1;
            default:   dp_cmd          = '0;
         endcase
      end
   end

endmodule

[rtl/core/ifrx_datapath.sv]
// ----------------------------------------------------------------------------
// ifrx_datapath
// Byte store, frame descriptor ring and result registers.
// ----------------------------------------------------------------------------
module ifrx_datapath
   import ifrx_pkg::*;
#(
   parameter int unsigned BYTE_DEPTH  = 256,
   parameter int unsigned FRAME_SLOTS = 16
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           dp_cmd,
   input  logic [DATA_W-1:0]    rx_byte,
   output logic [DATA_W-1:0]    rd_data,
   output logic                 rd_valid,
   output logic                 rd_last,
   output logic [WAITING_W-1:0] frames_waiting,
   output logic                 slots_full
);

   localparam int unsigned BW = $clog2(BYTE_DEPTH);
   localparam int unsigned SW = $clog2(FRAME_SLOTS);

   localparam logic [BW-1:0] BYTE_LAST = BW'(BYTE_DEPTH - 1);
   localparam logic [SW-1:0] SLOT_LAST = SW'(FRAME_SLOTS - 1);
   localparam logic [SW:0]   SLOT_CNT  = (SW + 1)'(FRAME_SLOTS);

   function automatic logic [BW-1:0] byte_inc(input logic [BW-1:0] p);
      return (p == BYTE_LAST) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [BW-1:0] byte_dec(input logic [BW-1:0] p);
      return (p == '0) ? BYTE_LAST : p - 1'b1;
   endfunction

   function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
      return (s == SLOT_LAST) ? '0 : s + 1'b1;
   endfunction

   logic [DATA_W-1:0] byte_store [BYTE_DEPTH];
   logic [DATA_W-1:0] mem_q_ff;

   logic [BW-1:0] frame_start_ff [FRAME_SLOTS];
   logic [BW-1:0] frame_end_ff   [FRAME_SLOTS];

   logic [BW-1:0] byte_wr_ff, byte_wr_in;
   logic [SW-1:0] slot_wr_ff, slot_wr_in;
   logic [SW-1:0] slot_rd_ff, slot_rd_in;
   logic          valid_ff, valid_in;
   logic          last_ff,  last_in;

   logic [BW-1:0] rd_start, rd_end;
   logic [SW-1:0] slot_wr_nxt, slot_rd_nxt;
   logic          frame_pending, frame_empty, open_ok;
   logic [SW:0]   slot_diff;

   assign rd_start      = frame_start_ff[slot_rd_ff];
   assign rd_end        = frame_end_ff[slot_rd_ff];
   assign slot_wr_nxt   = slot_inc(slot_wr_ff);
   assign slot_rd_nxt   = slot_inc(slot_rd_ff);
   assign frame_pending = (slot_rd_ff != slot_wr_ff);
   assign frame_empty   = (rd_start == byte_inc(rd_end));
   assign open_ok       = (slot_wr_nxt != slot_rd_ff);

   always_comb begin
      byte_wr_in = byte_wr_ff;
      slot_wr_in = slot_wr_ff;
      slot_rd_in = slot_rd_ff;
      valid_in   = valid_ff;
      last_in    = last_ff;
      if (dp_cmd.do_store) begin
         byte_wr_in = byte_inc(byte_wr_ff);
         valid_in   = 1'b0;
         last_in    = 1'b0;
      end else if (dp_cmd.do_idle) begin
         if (open_ok) slot_wr_in = slot_wr_nxt;
         valid_in = 1'b0;
         last_in  = 1'b0;
      end else if (dp_cmd.do_read) begin
         valid_in = 1'b0;
         last_in  = 1'b0;
         if (frame_pending) begin
            if (frame_empty) begin
               slot_rd_in = slot_rd_nxt;
            end else begin
               valid_in = 1'b1;
               last_in  = (rd_start == rd_end);
               if (rd_start == rd_end) slot_rd_in = slot_rd_nxt;
            end
         end
      end else if (dp_cmd.do_flush) begin
         byte_wr_in = '0;
         slot_wr_in = '0;
         slot_rd_in = '0;
         valid_in   = 1'b0;
         last_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_wr_ff <= '0;
         slot_wr_ff <= '0;
         slot_rd_ff <= '0;
         valid_ff   <= 1'b0;
         last_ff    <= 1'b0;
      end else begin
         byte_wr_ff <= byte_wr_in;
         slot_wr_ff <= slot_wr_in;
         slot_rd_ff <= slot_rd_in;
         valid_ff   <= valid_in;
         last_ff    <= last_in;
      end
   end

   // byte store: one write or one registered read per step
   always_ff @(posedge clock) begin
      if (dp_cmd.do_store) byte_store[byte_wr_ff] <= rx_byte;
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.do_read && frame_pending && !frame_empty) begin
         mem_q_ff <= byte_store[rd_start];
      end
   end

   // descriptors; slot 0 start comes up at zero
   always_ff @(posedge clock) begin
      if (reset || dp_cmd.do_flush) begin
         frame_start_ff[0] <= '0;
      end else if (dp_cmd.do_idle && open_ok) begin
         frame_start_ff[slot_wr_nxt] <= byte_wr_ff;
      end else if (dp_cmd.do_read && frame_pending && !frame_empty) begin
         frame_start_ff[slot_rd_ff] <= byte_inc(rd_start);
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.do_idle) frame_end_ff[slot_wr_ff] <= byte_dec(byte_wr_ff);
   end

   // status from the settled slot positions
   assign slot_diff = (slot_wr_ff >= slot_rd_ff)
                    ? {1'b0, slot_wr_ff} - {1'b0, slot_rd_ff}
                    : {1'b0, slot_wr_ff} + SLOT_CNT - {1'b0, slot_rd_ff};

   assign frames_waiting = WAITING_W'(slot_diff);
   assign slots_full     = (slot_wr_nxt == slot_rd_ff);
   assign rd_valid       = valid_ff;
   assign rd_last        = last_ff;
   assign rd_data        = valid_ff ? mem_q_ff : '0;

endmodule

[rtl/core/idle_framed_rx_byte_ring.sv]
// ----------------------------------------------------------------------------
// idle_framed_rx_byte_ring
// Receive byte ring split into frames at idle-line events.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command word: tuser = command (store byte, idle,
//   read one byte, flush), tdata = received byte for a store.
//   rsp_* returns exactly one word per command: the byte read (zero when
//   none), tuser = byte valid, tlast = last byte of its frame, plus the
//   number of closed frames waiting and the descriptor-ring-full flag.
//   Latency: the result is valid the cycle after the command is taken.
//   The controller takes a new word only once the previous result has been
//   taken, so it never takes a command while a result is pending.
//   If the receiver stalls, the result holds in the output registers and
//   req_tready stays low until it is taken.
//   Reset clears all positions and valid flags; stored bytes are not
//   cleared and a read never reaches an unwritten entry.
// ----------------------------------------------------------------------------
module idle_framed_rx_byte_ring
   import ifrx_pkg::*;
#(
   parameter int unsigned BYTE_DEPTH  = 256,
   parameter int unsigned FRAME_SLOTS = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] rd_data, [11:8] frames_waiting,
                                    // [12] slots_full, [15:13] zero
   output logic        rsp_tuser,   // [0] rd_valid
   output logic        rsp_tlast    // rd_last
);

   dp_cmd_type           dp_cmd;
   logic [DATA_W-1:0]    rd_data;
   logic                 rd_valid;
   logic                 rd_last;
   logic [WAITING_W-1:0] frames_waiting;
   logic                 slots_full;

   ifrx_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_cmd     (dp_cmd)
   );

   ifrx_datapath #(
      .BYTE_DEPTH  (BYTE_DEPTH),
      .FRAME_SLOTS (FRAME_SLOTS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .dp_cmd         (dp_cmd),
      .rx_byte        (req_tdata),
      .rd_data        (rd_data),
      .rd_valid       (rd_valid),
      .rd_last        (rd_last),
      .frames_waiting (frames_waiting),
      .slots_full     (slots_full)
   );

   // result word packing
   assign rsp_tdata = {3'b000, slots_full, frames_waiting, rd_data};
   assign rsp_tuser = rd_valid;
   assign rsp_tlast = rd_last;

`ifndef SYNTHESIS
   // one word in flight: never taking input while a result is pending
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while result pending");

   // every accepted word produces a result next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("no result after accepted word");

   // no byte means no last flag and zero data
   a_invalid_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (!rsp_tlast && rsp_tdata[7:0] == 8'd0))
      else $error("stray data or last on invalid result");

   // a non-read command never returns a byte
   a_read_only: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser != CMD_READ) |=> !rsp_tuser)
      else $error("byte returned for non-read command");
`endif

endmodule
